// ----- hw/rtl/mfp_pkg.sv -----
// Shared codes and types of the movement fragment parser.
package mfp_pkg;

   // Result status codes.
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_STOP  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Fragment kinds.
   localparam logic [1:0] KIND_ABS  = 2'd0;
   localparam logic [1:0] KIND_REL  = 2'd1;
   localparam logic [1:0] KIND_JUMP = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   // Byte actions: codes below ACT_STANCE are field slot * 2, plus one for the high byte.
   localparam logic [3:0] ACT_STANCE = 4'd12;
   localparam logic [3:0] ACT_SKIP   = 4'd13;

   // Highest command code that has a layout.
   localparam logic [7:0] MAX_CMD = 8'd22;

   localparam int NUM_FIELDS = 6;

   // Per-byte decision for the fragment body.
   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] last_idx;
      logic [3:0] act;
   } lay_info_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         command;
      logic [1:0]         kind;
      logic signed [15:0] x_position;
      logic signed [15:0] y_position;
      logic signed [15:0] x_wobble;
      logic signed [15:0] y_wobble;
      logic signed [15:0] foothold;
      logic [7:0]         new_stance;
      logic signed [15:0] duration;
      logic               last_fragment;
   } result_type;

endpackage

// ----- hw/rtl/mfp_layout.sv -----
// Command layout table: kind, body length and action for each body byte.
module mfp_layout (
   input  logic [7:0]           cmd,
   input  logic [3:0]           idx,
   output mfp_pkg::lay_info_type info
);

   localparam logic [2:0] LAY_ABS   = 3'd0;
   localparam logic [2:0] LAY_REL   = 3'd1;
   localparam logic [2:0] LAY_TELE  = 3'd2;
   localparam logic [2:0] LAY_JD    = 3'd3;
   localparam logic [2:0] LAY_SKIP1 = 3'd4;
   localparam logic [2:0] LAY_SKIP9 = 3'd5;
   localparam logic [2:0] LAY_SKIP3 = 3'd6;
   localparam logic [2:0] LAY_BAD   = 3'd7;

   logic [2:0] lay;

   always_comb begin
      case (cmd)
         8'd0, 8'd5, 8'd17: lay = LAY_ABS;
         8'd1, 8'd2, 8'd6, 8'd12, 8'd13, 8'd16, 8'd18, 8'd19, 8'd20, 8'd22: lay = LAY_REL;
         8'd3, 8'd4, 8'd7, 8'd8, 8'd9, 8'd11: lay = LAY_TELE;
         8'd15: lay = LAY_JD;
         8'd10: lay = LAY_SKIP1;
         8'd14: lay = LAY_SKIP9;
         8'd21: lay = LAY_SKIP3;
         default: lay = LAY_BAD;
      endcase
   end

   always_comb begin
      info.act      = mfp_pkg::ACT_SKIP;
      info.kind     = mfp_pkg::KIND_NONE;
      info.last_idx = 4'd0;
      case (lay)
         LAY_ABS: begin
            info.kind     = mfp_pkg::KIND_ABS;
            info.last_idx = 4'd12;
            if (idx <= 4'd9) info.act = idx;
            else if (idx == 4'd10) info.act = mfp_pkg::ACT_STANCE;
            else if (idx == 4'd11) info.act = 4'd10;
            else if (idx == 4'd12) info.act = 4'd11;
         end
         LAY_REL: begin
            info.kind     = mfp_pkg::KIND_REL;
            info.last_idx = 4'd6;
            if (idx <= 4'd3) info.act = idx;
            else if (idx == 4'd4) info.act = mfp_pkg::ACT_STANCE;
            else if (idx == 4'd5) info.act = 4'd10;
            else if (idx == 4'd6) info.act = 4'd11;
         end
         LAY_TELE: begin
            info.kind     = mfp_pkg::KIND_ABS;
            info.last_idx = 4'd8;
            if (idx <= 4'd7) info.act = idx;
            else if (idx == 4'd8) info.act = mfp_pkg::ACT_STANCE;
         end
         LAY_JD: begin
            // Two bytes after the foothold are skipped.
            info.kind     = mfp_pkg::KIND_JUMP;
            info.last_idx = 4'd14;
            if (idx <= 4'd9) info.act = idx;
            else if (idx == 4'd12) info.act = mfp_pkg::ACT_STANCE;
            else if (idx == 4'd13) info.act = 4'd10;
            else if (idx == 4'd14) info.act = 4'd11;
         end
         LAY_SKIP1: info.last_idx = 4'd0;
         LAY_SKIP9: info.last_idx = 4'd8;
         LAY_SKIP3: info.last_idx = 4'd2;
         default: info.last_idx = 4'd0;
      endcase
   end

endmodule

// ----- hw/rtl/mfp_parser.sv -----
// Packet state machine and field gathering; builds one result per finished fragment, stop command or empty packet.
module mfp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 packet_start,
   output logic                 res_valid,
   output mfp_pkg::result_type  res
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_CMD  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  frag_ff, frag_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [3:0]  idx_ff, idx_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  stance_ff, stance_in;
   logic [15:0] field_ff [mfp_pkg::NUM_FIELDS];
   logic [15:0] field_in [mfp_pkg::NUM_FIELDS];
   mfp_pkg::lay_info_type info;

   mfp_layout u_layout (
      .cmd  (cmd_ff),
      .idx  (idx_ff),
      .info (info)
   );

   always_comb begin
      phase_in  = phase_ff;
      frag_in   = frag_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      low_in    = low_ff;
      stance_in = stance_ff;
      for (int i = 0; i < mfp_pkg::NUM_FIELDS; i++) field_in[i] = field_ff[i];
      res_valid         = 1'b0;
      res.status        = mfp_pkg::ST_DONE;
      res.command       = cmd_ff;
      res.kind          = mfp_pkg::KIND_NONE;
      res.last_fragment = 1'b0;

      if (step) begin
         if (packet_start) begin
            // A start byte always opens a new packet, dropping any fragment in progress.
            frag_in   = data_byte;
            idx_in    = 4'd0;
            stance_in = 8'd0;
            for (int i = 0; i < mfp_pkg::NUM_FIELDS; i++) field_in[i] = 16'd0;
            if (data_byte == 8'd0) begin
               phase_in          = PH_IDLE;
               cmd_in            = 8'd0;
               res_valid         = 1'b1;
               res.status        = mfp_pkg::ST_EMPTY;
               res.command       = 8'd0;
               res.last_fragment = 1'b1;
            end else begin
               phase_in = PH_CMD;
            end
         end else if (phase_ff == PH_CMD) begin
            cmd_in    = data_byte;
            idx_in    = 4'd0;
            stance_in = 8'd0;
            for (int i = 0; i < mfp_pkg::NUM_FIELDS; i++) field_in[i] = 16'd0;
            if (data_byte > mfp_pkg::MAX_CMD) begin
               phase_in          = PH_IDLE;
               frag_in           = 8'd0;
               res_valid         = 1'b1;
               res.status        = mfp_pkg::ST_STOP;
               res.command       = data_byte;
               res.last_fragment = 1'b1;
            end else begin
               phase_in = PH_BODY;
            end
         end else if (phase_ff == PH_BODY) begin
            if (info.act < mfp_pkg::ACT_STANCE) begin
               if (info.act[0]) field_in[info.act[3:1]] = {data_byte, low_ff};
               else low_in = data_byte;
            end else if (info.act == mfp_pkg::ACT_STANCE) begin
               stance_in = data_byte;
            end
            idx_in = idx_ff + 4'd1;
            if (idx_ff == info.last_idx) begin
               frag_in           = frag_ff - 8'd1;
               idx_in            = 4'd0;
               res_valid         = 1'b1;
               res.kind          = info.kind;
               res.last_fragment = (frag_in == 8'd0);
               phase_in          = res.last_fragment ? PH_IDLE : PH_CMD;
            end
         end
      end

      res.x_position = $signed(field_in[0]);
      res.y_position = $signed(field_in[1]);
      res.x_wobble   = $signed(field_in[2]);
      res.y_wobble   = $signed(field_in[3]);
      res.foothold   = $signed(field_in[4]);
      res.duration   = $signed(field_in[5]);
      res.new_stance = stance_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         frag_ff  <= 8'd0;
         cmd_ff   <= 8'd0;
         idx_ff   <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         frag_ff  <= frag_in;
         cmd_ff   <= cmd_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff    <= low_in;
      stance_ff <= stance_in;
      for (int i = 0; i < mfp_pkg::NUM_FIELDS; i++) field_ff[i] <= field_in[i];
   end

`ifndef SYNTH
   a_body_known_cmd: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> cmd_ff <= mfp_pkg::MAX_CMD)
      else $error("Fragment body is being gathered for an unknown command.");

   a_idle_index_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> idx_ff == 4'd0)
      else $error("Byte index is not cleared while idle.");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.last_fragment |=> phase_ff == PH_IDLE)
      else $error("Parser did not return to idle after the last result.");
`endif

endmodule

// ----- hw/rtl/movement_fragment_parser_unit.sv -----
// Top level of the movement fragment parser: input register, parser and result register.
//
//   channel | direction | transaction
//   req_    | in        | one packet byte with its packet start flag
//   rsp_    | out       | one finished fragment, stop or empty-packet result
//
// One byte is accepted every cycle unless a stalled result holds the input register; a result
// passes the input register, then the result register, before it is visible.
// The parser state advances only when the result register is free or being emptied,
// so a stalled result holds the input register and req_ready falls only then.
// Reset is synchronous and clears the packet state; the parser then waits for a start byte.
module movement_fragment_parser_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_packet_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_command,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_x_position,
   output logic signed [15:0] rsp_y_position,
   output logic signed [15:0] rsp_x_wobble,
   output logic signed [15:0] rsp_y_wobble,
   output logic signed [15:0] rsp_foothold,
   output logic [7:0]         rsp_new_stance,
   output logic signed [15:0] rsp_duration,
   output logic               rsp_last_fragment
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_start_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   mfp_pkg::result_type rsp_ff;
   logic                adv;
   logic                step;
   logic                res_valid;
   mfp_pkg::result_type res;

   assign adv         = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !in_valid_ff || adv;
   assign step        = in_valid_ff && adv;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !adv);
   assign rsp_valid_in = adv ? res_valid : rsp_valid_ff;

   mfp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .packet_start (in_start_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_packet_start;
      end
      if (adv && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_command       = rsp_ff.command;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_x_position    = rsp_ff.x_position;
   assign rsp_y_position    = rsp_ff.y_position;
   assign rsp_x_wobble      = rsp_ff.x_wobble;
   assign rsp_y_wobble      = rsp_ff.y_wobble;
   assign rsp_foothold      = rsp_ff.foothold;
   assign rsp_new_stance    = rsp_ff.new_stance;
   assign rsp_duration      = rsp_ff.duration;
   assign rsp_last_fragment = rsp_ff.last_fragment;

`ifndef SYNTH
   a_blocked_byte_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !adv |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_start_ff))
      else $error("A blocked input byte was lost from the input register.");

   a_special_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != mfp_pkg::ST_DONE |-> rsp_ff.last_fragment)
      else $error("A stop or empty-packet result does not end the packet.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("A waiting result changed before it was taken.");
`endif

endmodule
